>>> hdl/rmq_pkg.sv
// Shared types and codes for the rotation matrix to quaternion block.
// No dependencies.
package rmq_pkg;

    typedef logic [1:0] t_branch;

    localparam t_branch BR_TRACE = 2'd0;
    localparam t_branch BR_X     = 2'd1;
    localparam t_branch BR_Y     = 2'd2;
    localparam t_branch BR_Z     = 2'd3;

endpackage

>>> hdl/rmq_front.sv
// Front stage: branch choice, clamped radicand and per-component numerators.
// Depends on rmq_pkg.
module rmq_front #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14,
    parameter int RAD_WIDTH  = 20
) (
    input  logic                         i_clk,
    input  logic signed [DATA_WIDTH-1:0] i_m [9],
    output logic [RAD_WIDTH-1:0]         o_rad,
    output logic [DATA_WIDTH:0]          o_mag [4],
    output logic                         o_neg [4],
    output rmq_pkg::t_branch             o_br
);
    localparam int W   = DATA_WIDTH;
    localparam int RSW = RAD_WIDTH + 1;

    logic signed [W+1:0]      tr;
    logic signed [RSW-1:0]    one, d0, d1, d2, rad;
    logic signed [W:0]        num [4];
    logic signed [W:0]        e [9];
    rmq_pkg::t_branch         br;

    logic [RAD_WIDTH-1:0]     r_rad;
    logic [W:0]               r_mag [4];
    logic                     r_neg [4];
    rmq_pkg::t_branch         r_br;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            e[i] = (W+1)'(i_m[i]);
        end
        one = RSW'(1) <<< FRAC_BITS;
        d0  = RSW'(i_m[0]);
        d1  = RSW'(i_m[4]);
        d2  = RSW'(i_m[8]);
        tr  = (W+2)'(i_m[0]) + (W+2)'(i_m[4]) + (W+2)'(i_m[8]);
        if (tr > 0) begin
            br  = rmq_pkg::BR_TRACE;
            rad = one + d0 + d1 + d2;
        end else if (i_m[0] > i_m[4] && i_m[0] > i_m[8]) begin
            br  = rmq_pkg::BR_X;
            rad = one + d0 - d1 - d2;
        end else if (i_m[4] > i_m[8]) begin
            br  = rmq_pkg::BR_Y;
            rad = one + d1 - d0 - d2;
        end else begin
            br  = rmq_pkg::BR_Z;
            rad = one + d2 - d0 - d1;
        end
        // indices: 0 r00 1 r01 2 r02 3 r10 4 r11 5 r12 6 r20 7 r21 8 r22
        case (br)
            rmq_pkg::BR_TRACE: begin
                num[0] = '0;
                num[1] = e[7] - e[5];
                num[2] = e[2] - e[6];
                num[3] = e[3] - e[1];
            end
            rmq_pkg::BR_X: begin
                num[0] = e[7] - e[5];
                num[1] = '0;
                num[2] = e[1] + e[3];
                num[3] = e[2] + e[6];
            end
            rmq_pkg::BR_Y: begin
                num[0] = e[2] - e[6];
                num[1] = e[1] + e[3];
                num[2] = '0;
                num[3] = e[5] + e[7];
            end
            default: begin
                num[0] = e[3] - e[1];
                num[1] = e[2] + e[6];
                num[2] = e[5] + e[7];
                num[3] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rad <= rad[RSW-1] ? '0 : rad[RAD_WIDTH-1:0];
        r_br  <= br;
        for (int c = 0; c < 4; c++) begin
            r_neg[c] <= num[c][W];
            r_mag[c] <= num[c][W] ? (W+1)'(-num[c]) : (W+1)'(num[c]);
        end
    end

    assign o_rad = r_rad;
    assign o_mag = r_mag;
    assign o_neg = r_neg;
    assign o_br  = r_br;
endmodule

>>> hdl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// No dependencies.
module rmq_sqrt #(
    parameter int IN_WIDTH = 34
) (
    input  logic                        i_clk,
    input  logic [IN_WIDTH-1:0]         i_x,
    output logic [(IN_WIDTH+1)/2-1:0]   o_root
);
    localparam int HW  = (IN_WIDTH + 1) / 2;
    localparam int XW  = 2 * HW;
    localparam int RMW = HW + 3;

    logic [RMW-1:0] r_rem  [HW];
    logic [HW-1:0]  r_root [HW];
    logic [XW-1:0]  r_x    [HW];

    for (genvar k = 0; k < HW; k++) begin : g_stage
        logic [RMW-1:0] prem, cur, trial;
        logic [HW-1:0]  proot;
        logic [XW-1:0]  px;

        if (k == 0) begin : g_first
            assign prem  = '0;
            assign proot = '0;
            assign px    = XW'(i_x);
        end else begin : g_next
            assign prem  = r_rem[k-1];
            assign proot = r_root[k-1];
            assign px    = r_x[k-1];
        end

        assign cur   = {prem[RMW-3:0], px[XW-1 -: 2]};
        assign trial = {1'b0, proot, 2'b01};

        always_ff @(posedge i_clk) begin
            r_x[k] <= px << 2;
            if (cur >= trial) begin
                r_rem[k]  <= cur - trial;
                r_root[k] <= {proot[HW-2:0], 1'b1};
            end else begin
                r_rem[k]  <= cur;
                r_root[k] <= {proot[HW-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root[HW-1];
endmodule

>>> hdl/rmq_div.sv
// One divider lane: pipelined restoring division, one quotient bit per stage.
// No dependencies.
module rmq_div #(
    parameter int NUM_WIDTH = 34,
    parameter int DIV_WIDTH = 18
) (
    input  logic                 i_clk,
    input  logic [NUM_WIDTH-1:0] i_num,
    input  logic [DIV_WIDTH-1:0] i_den,
    output logic [NUM_WIDTH-1:0] o_quot
);
    localparam int QW = NUM_WIDTH;
    localparam int DW = DIV_WIDTH;

    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_x   [QW];
    logic [QW-1:0] r_q   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] prem, pden;
        logic [QW-1:0] px, pq;
        logic [DW:0]   cur, diff;

        if (k == 0) begin : g_first
            assign prem = '0;
            assign pden = i_den;
            assign px   = i_num;
            assign pq   = '0;
        end else begin : g_next
            assign prem = r_rem[k-1];
            assign pden = r_den[k-1];
            assign px   = r_x[k-1];
            assign pq   = r_q[k-1];
        end

        assign cur  = {prem, px[QW-1]};
        assign diff = cur - {1'b0, pden};

        always_ff @(posedge i_clk) begin
            r_den[k] <= pden;
            r_x[k]   <= px << 1;
            if (cur >= {1'b0, pden}) begin
                r_rem[k] <= diff[DW-1:0];
                r_q[k]   <= {pq[QW-2:0], 1'b1};
            end else begin
                r_rem[k] <= cur[DW-1:0];
                r_q[k]   <= {pq[QW-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_q[QW-1];
endmodule

>>> hdl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion, four-branch method, fully pipelined.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div.
//
//  channel | direction | handshake          | fields
//  matrix  | in        | start / busy       | i_r00 .. i_r22
//  quat    | out       | o_valid (1 cycle)  | o_quat_w/x/y/z, o_branch_used, o_degenerate
//
// One item per cycle; busy is held low. Data passes the front register, the
// (RAD+F+1)/2 root stages, the DATA_WIDTH+1+FRAC_BITS quotient stages and
// the output register, the divider lanes setting the depth. Reset clears
// only the valid pipeline. The receiver cannot stall; each result shows for one cycle.
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_r00,
    input  logic signed [DATA_WIDTH-1:0] i_r01,
    input  logic signed [DATA_WIDTH-1:0] i_r02,
    input  logic signed [DATA_WIDTH-1:0] i_r10,
    input  logic signed [DATA_WIDTH-1:0] i_r11,
    input  logic signed [DATA_WIDTH-1:0] i_r12,
    input  logic signed [DATA_WIDTH-1:0] i_r20,
    input  logic signed [DATA_WIDTH-1:0] i_r21,
    input  logic signed [DATA_WIDTH-1:0] i_r22,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_quat_w,
    output logic signed [DATA_WIDTH-1:0] o_quat_x,
    output logic signed [DATA_WIDTH-1:0] o_quat_y,
    output logic signed [DATA_WIDTH-1:0] o_quat_z,
    output logic [1:0]                   o_branch_used,
    output logic                         o_degenerate
);
    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int RW  = ((W > F + 1) ? W : F + 1) + 2;
    localparam int IW  = RW + F;
    localparam int HW  = (IW + 1) / 2;
    localparam int QW  = W + 1 + F;
    localparam int DW  = HW + 1;
    localparam int XW  = QW + HW;
    localparam int LAT = 2 + HW + QW;

    localparam logic [XW-1:0] LIM_P = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [XW-1:0] LIM_N = LIM_P + XW'(1);

    logic signed [W-1:0] m [9];
    logic [RW-1:0]       f_rad;
    logic [W:0]          f_mag [4];
    logic                f_neg [4];
    rmq_pkg::t_branch    f_br;
    logic [HW-1:0]       h;
    logic [QW-1:0]       quot [4];

    logic [W:0]          r_mag_a [HW][4];
    logic                r_neg_a [HW][4];
    rmq_pkg::t_branch    r_br_a  [HW];
    logic                r_neg_b [QW][4];
    rmq_pkg::t_branch    r_br_b  [QW];
    logic [HW-1:0]       r_h_b   [QW];
    logic [LAT-1:0]      r_vld;

    logic signed [W-1:0] r_q [4];
    rmq_pkg::t_branch    r_br_o;
    logic                r_deg;
    logic signed [W-1:0] n_q [4];
    logic                n_deg;

    assign busy = 1'b0;
    assign m = '{i_r00, i_r01, i_r02, i_r10, i_r11, i_r12, i_r20, i_r21, i_r22};

    rmq_front #(.DATA_WIDTH(W), .FRAC_BITS(F), .RAD_WIDTH(RW)) u_front (
        .i_clk (i_clk),
        .i_m   (m),
        .o_rad (f_rad),
        .o_mag (f_mag),
        .o_neg (f_neg),
        .o_br  (f_br)
    );

    rmq_sqrt #(.IN_WIDTH(IW)) u_sqrt (
        .i_clk  (i_clk),
        .i_x    ({f_rad, {F{1'b0}}}),
        .o_root (h)
    );

    // sideband follows the root pipeline, then the divider pipeline
    always_ff @(posedge i_clk) begin
        r_mag_a[0] <= f_mag;
        r_neg_a[0] <= f_neg;
        r_br_a[0]  <= f_br;
        for (int k = 1; k < HW; k++) begin
            r_mag_a[k] <= r_mag_a[k-1];
            r_neg_a[k] <= r_neg_a[k-1];
            r_br_a[k]  <= r_br_a[k-1];
        end
        r_neg_b[0] <= r_neg_a[HW-1];
        r_br_b[0]  <= r_br_a[HW-1];
        r_h_b[0]   <= h;
        for (int k = 1; k < QW; k++) begin
            r_neg_b[k] <= r_neg_b[k-1];
            r_br_b[k]  <= r_br_b[k-1];
            r_h_b[k]   <= r_h_b[k-1];
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_lane
        rmq_div #(.NUM_WIDTH(QW), .DIV_WIDTH(DW)) u_div (
            .i_clk  (i_clk),
            .i_num  ({r_mag_a[HW-1][c], {F{1'b0}}}),
            .i_den  ({h, 1'b0}),
            .o_quot (quot[c])
        );
    end

    // merge: own component is h/2 (saturated), others the saturated signed quotient, or zero when h is zero
    always_comb begin
        logic [XW-1:0] qx, own, negq;
        own   = XW'(r_h_b[QW-1] >> 1);
        n_deg = (r_h_b[QW-1] == '0);
        for (int c = 0; c < 4; c++) begin
            qx   = XW'(quot[c]);
            negq = -qx;
            if (r_br_b[QW-1] == 2'(c)) begin
                n_q[c] = (own > LIM_P) ? LIM_P[W-1:0] : own[W-1:0];
            end else if (n_deg) begin
                n_q[c] = '0;
            end else if (r_neg_b[QW-1][c]) begin
                n_q[c] = (qx > LIM_N) ? LIM_N[W-1:0] : negq[W-1:0];
            end else begin
                n_q[c] = (qx > LIM_P) ? LIM_P[W-1:0] : qx[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q    <= n_q;
        r_br_o <= r_br_b[QW-1];
        r_deg  <= n_deg;
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    assign o_valid       = r_vld[LAT-1];
    assign o_quat_w      = r_q[0];
    assign o_quat_x      = r_q[1];
    assign o_quat_y      = r_q[2];
    assign o_quat_z      = r_q[3];
    assign o_branch_used = r_br_o;
    assign o_degenerate  = r_deg;
endmodule
